### hdl/lbc_pkg.sv
// line_box_clip package: widths, register codes, face mapping, side-band type
// and output saturation; no dependencies
package lbc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CRD_W = 32;
  localparam int EXT_W = 31;
  localparam int NFACE = 6;
  localparam int NDIV = 12;
  localparam int NMAG_W = 33;
  localparam int DMAG_W = 32;
  localparam int PROD_W = NMAG_W + DMAG_W;
  localparam int NUM_W = 65;
  localparam int DEN_W = 33;
  localparam int Q_W = 41;
  localparam int DIV_LAT = Q_W + 1;
  localparam int H_W = 43;

  localparam logic [Q_W-1:0] Q_LIMIT = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_X_EXT = 2'd0,
    REG_Y_EXT = 2'd1,
    REG_Z_EXT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][CRD_W-1:0] p;
    logic [2:0]            dnz;
    logic [NDIV-1:0]       neg;
  } lbc_side_t;

  // faces: z=0, y=0, x=0, z=max, y=max, x=max
  function automatic int face_axis(input int f);
    int a;
    case (f)
      0, 3:    a = 2;
      1, 4:    a = 1;
      default: a = 0;
    endcase
    return a;
  endfunction

  // the two non-face axes, ascending
  function automatic int face_other(input int f, input int m);
    int a;
    int o;
    a = face_axis(f);
    if (m == 0) begin
      o = (a == 0) ? 1 : 0;
    end else begin
      o = (a == 2) ? 1 : 2;
    end
    return o;
  endfunction

  function automatic logic [CRD_W-1:0] sat32(input logic signed [H_W-1:0] h);
    logic [CRD_W-1:0] r;
    if (h > $signed(H_W'(32'h7fff_ffff))) begin
      r = 32'h7fff_ffff;
    end else if (h < -$signed(H_W'(33'h0_8000_0000))) begin
      r = 32'h8000_0000;
    end else begin
      r = h[CRD_W-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/lbc_div.sv
// line_box_clip pipelined truncating divider, one quotient bit per stage
// depends on lbc_pkg
module lbc_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [lbc_pkg::NUM_W-1:0]  num,
  input  logic [lbc_pkg::DEN_W-1:0]  den,
  output logic [lbc_pkg::Q_W-1:0]    q
);

  localparam int QW = lbc_pkg::Q_W;
  localparam int DW = lbc_pkg::DEN_W;
  localparam int NW = lbc_pkg::NUM_W;

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] lo_r  [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] q_r   [QW+1];
  logic          ovf_r [QW+1];

  // high part decides overflow of the quotient range
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DW'(num[NW-1:QW]);
      ovf_r[0] <= (DW'(num[NW-1:QW]) >= den);
      lo_r[0]  <= num[QW-1:0];
      den_r[0] <= den;
      q_r[0]   <= '0;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [DW:0] t;
    logic        ge;
    assign t  = {rem_r[s], lo_r[s][QW-1]};
    assign ge = (t >= {1'b0, den_r[s]});

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s+1]   <= {q_r[s][QW-2:0], ge};
        ovf_r[s+1] <= ovf_r[s];
      end
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= ge ? DW'(t - {1'b0, den_r[s]}) : DW'(t);
          lo_r[s+1]  <= {lo_r[s][QW-2:0], 1'b0};
          den_r[s+1] <= den_r[s];
        end
      end
    end
  end

  assign q = (ovf_r[QW] || (q_r[QW] > lbc_pkg::Q_LIMIT)) ? lbc_pkg::Q_LIMIT : q_r[QW];

endmodule

### hdl/line_box_clip.sv
// throughput: one request per cycle while the output is not stalled;
// every stage, the 42-stage dividers included, takes one each cycle
// an output stall while out_valid is high freezes the whole pipeline and the input in the same cycle
// reset (synchronous, active low) clears all valid bits and the box extents
// depends on lbc_pkg and lbc_div
module line_box_clip #(
  parameter int FRAC_BITS = lbc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [lbc_pkg::CRD_W-1:0]  in_point_x,
  input  logic signed [lbc_pkg::CRD_W-1:0]  in_point_y,
  input  logic signed [lbc_pkg::CRD_W-1:0]  in_point_z,
  input  logic signed [lbc_pkg::CRD_W-1:0]  in_dir_x,
  input  logic signed [lbc_pkg::CRD_W-1:0]  in_dir_y,
  input  logic signed [lbc_pkg::CRD_W-1:0]  in_dir_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic signed [lbc_pkg::CRD_W-1:0]  out_end1_x,
  output logic signed [lbc_pkg::CRD_W-1:0]  out_end1_y,
  output logic signed [lbc_pkg::CRD_W-1:0]  out_end1_z,
  output logic signed [lbc_pkg::CRD_W-1:0]  out_end2_x,
  output logic signed [lbc_pkg::CRD_W-1:0]  out_end2_y,
  output logic signed [lbc_pkg::CRD_W-1:0]  out_end2_z,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [lbc_pkg::EXT_W-1:0]         cfg_data
);

  localparam int CW = lbc_pkg::CRD_W;
  localparam int EW = lbc_pkg::EXT_W;
  localparam int HW = lbc_pkg::H_W;
  localparam int NF = lbc_pkg::NFACE;
  localparam int ND = lbc_pkg::NDIV;
  localparam int MW = lbc_pkg::NMAG_W;
  localparam int DMW = lbc_pkg::DMAG_W;
  localparam int PW = lbc_pkg::PROD_W;
  localparam int NW = lbc_pkg::NUM_W;
  localparam int DW = lbc_pkg::DEN_W;
  localparam int QW = lbc_pkg::Q_W;
  localparam int DL = lbc_pkg::DIV_LAT;
  localparam logic signed [HW-1:0] TOL = HW'(((1 << FRAC_BITS) + 500) / 1000);

  logic adv;
  logic out_valid_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // extent registers
  logic [EW-1:0] ext_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r[0] <= '0;
      ext_r[1] <= '0;
      ext_r[2] <= '0;
    end else if (cfg_we) begin
      case (lbc_pkg::cfg_reg_t'(cfg_index))
        lbc_pkg::REG_X_EXT: ext_r[0] <= cfg_data;
        lbc_pkg::REG_Y_EXT: ext_r[1] <= cfg_data;
        lbc_pkg::REG_Z_EXT: ext_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage a: capture request
  logic                 va_r;
  logic signed [CW-1:0] pa_r [3];
  logic signed [CW-1:0] da_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r[0] <= in_point_x;
      pa_r[1] <= in_point_y;
      pa_r[2] <= in_point_z;
      da_r[0] <= in_dir_x;
      da_r[1] <= in_dir_y;
      da_r[2] <= in_dir_z;
    end
  end

  // stage b: plane offsets and magnitudes
  logic [MW-1:0]  nmag_b;
  logic [MW-1:0]  nmag_nxt [NF];
  logic [NF-1:0]  nneg_nxt;
  logic [DMW-1:0] dmag_nxt [3];

  always_comb begin
    logic signed [MW:0] n;
    for (int f = 0; f < NF; f++) begin
      if (f < 3) begin
        n = -(MW+1)'(pa_r[lbc_pkg::face_axis(f)]);
      end else begin
        n = $signed((MW+1)'(ext_r[lbc_pkg::face_axis(f)]))
            - (MW+1)'(pa_r[lbc_pkg::face_axis(f)]);
      end
      nneg_nxt[f] = n[MW];
      nmag_nxt[f] = n[MW] ? MW'(-n) : MW'(n);
    end
    for (int k = 0; k < 3; k++) begin
      dmag_nxt[k] = da_r[k][CW-1] ? DMW'(-da_r[k]) : DMW'(da_r[k]);
    end
    nmag_b = nmag_nxt[0];
  end

  logic                 vb_r;
  logic signed [CW-1:0] pb_r [3];
  logic [MW-1:0]        nmag_b_r [NF];
  logic [NF-1:0]        nneg_b_r;
  logic [DMW-1:0]       dmag_b_r [3];
  logic [2:0]           dneg_b_r;
  logic [2:0]           dnz_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nmag_b_r[0] <= nmag_b;
      for (int f = 1; f < NF; f++) begin
        nmag_b_r[f] <= nmag_nxt[f];
      end
      nneg_b_r <= nneg_nxt;
      for (int k = 0; k < 3; k++) begin
        pb_r[k]     <= pa_r[k];
        dmag_b_r[k] <= dmag_nxt[k];
        dneg_b_r[k] <= da_r[k][CW-1];
        dnz_b_r[k]  <= (da_r[k] != '0);
      end
    end
  end

  // stage c: products and quotient signs
  logic                vc_r;
  logic [PW-1:0]       prod_c_r [ND];
  logic [DMW-1:0]      dmag_c_r [3];
  lbc_pkg::lbc_side_t  side_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (adv) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int f = 0; f < NF; f++) begin
        for (int m = 0; m < 2; m++) begin
          prod_c_r[2*f+m] <= PW'(dmag_b_r[lbc_pkg::face_other(f, m)]) * PW'(nmag_b_r[f]);
          side_c_r.neg[2*f+m] <= dneg_b_r[lbc_pkg::face_other(f, m)] ^ nneg_b_r[f]
                                 ^ dneg_b_r[lbc_pkg::face_axis(f)];
        end
      end
      for (int k = 0; k < 3; k++) begin
        dmag_c_r[k]     <= dmag_b_r[k];
        side_c_r.p[k]   <= pb_r[k];
      end
      side_c_r.dnz <= dnz_b_r;
    end
  end

  // dividers: round(num / den) as floor((2num + den) / 2den)
  logic [NW-1:0] num_c [ND];
  logic [DW-1:0] den_c [3];
  logic [QW-1:0] quo   [ND];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      den_c[k] = {dmag_c_r[k], 1'b0};
    end
    for (int f = 0; f < NF; f++) begin
      for (int m = 0; m < 2; m++) begin
        num_c[2*f+m] = NW'({prod_c_r[2*f+m][PW-2:0], 1'b0})
                       + NW'(dmag_c_r[lbc_pkg::face_axis(f)]);
      end
    end
  end

  for (genvar i = 0; i < ND; i++) begin : g_div
    lbc_div u_div (
      .clk (clk),
      .en  (adv),
      .num (num_c[i]),
      .den (den_c[lbc_pkg::face_axis(i / 2)]),
      .q   (quo[i])
    );
  end

  // side-band line alongside the dividers
  logic               sv_r   [DL];
  lbc_pkg::lbc_side_t side_r [DL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DL; j++) begin
        sv_r[j] <= 1'b0;
      end
    end else if (adv) begin
      sv_r[0] <= vc_r;
      for (int j = 1; j < DL; j++) begin
        sv_r[j] <= sv_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_c_r;
      for (int j = 1; j < DL; j++) begin
        side_r[j] <= side_r[j-1];
      end
    end
  end

  // stage e: hit points and box test
  lbc_pkg::lbc_side_t   side_e;
  logic signed [HW-1:0] h_nxt  [NF][3];
  logic [NF-1:0]        ok_nxt;

  assign side_e = side_r[DL-1];

  always_comb begin
    logic signed [HW-1:0] pe;
    logic signed [HW-1:0] qe;
    logic                 in_box;
    for (int f = 0; f < NF; f++) begin
      for (int k = 0; k < 3; k++) begin
        h_nxt[f][k] = '0;
      end
      if (f < 3) begin
        h_nxt[f][lbc_pkg::face_axis(f)] = '0;
      end else begin
        h_nxt[f][lbc_pkg::face_axis(f)] = $signed(HW'(ext_r[lbc_pkg::face_axis(f)]));
      end
      for (int m = 0; m < 2; m++) begin
        pe = HW'($signed(side_e.p[lbc_pkg::face_other(f, m)]));
        qe = $signed(HW'(quo[2*f+m]));
        h_nxt[f][lbc_pkg::face_other(f, m)] = side_e.neg[2*f+m] ? (pe - qe) : (pe + qe);
      end
      in_box = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (h_nxt[f][k] < -TOL || h_nxt[f][k] > $signed(HW'(ext_r[k])) + TOL) begin
          in_box = 1'b0;
        end
      end
      ok_nxt[f] = in_box && side_e.dnz[lbc_pkg::face_axis(f)];
    end
  end

  logic                 ve_r;
  logic signed [HW-1:0] he_r [NF][3];
  logic [NF-1:0]        oke_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (adv) begin
      ve_r <= sv_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      he_r  <= h_nxt;
      oke_r <= ok_nxt;
    end
  end

  // stage f: pairwise equality against earlier faces
  logic [NF-1:0] eq_nxt [NF];

  always_comb begin
    for (int f = 0; f < NF; f++) begin
      for (int j = 0; j < NF; j++) begin
        eq_nxt[f][j] = (j < f) && (he_r[f][0] == he_r[j][0])
                       && (he_r[f][1] == he_r[j][1]) && (he_r[f][2] == he_r[j][2]);
      end
    end
  end

  logic                 vf_r;
  logic signed [HW-1:0] hf_r [NF][3];
  logic [NF-1:0]        okf_r;
  logic [NF-1:0]        eqf_r [NF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (adv) begin
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hf_r  <= he_r;
      okf_r <= oke_r;
      eqf_r <= eq_nxt;
    end
  end

  // stage g: keep distinct hits, pick the first two; found only if exactly two are kept
  logic [2:0]    cnt;
  logic [2:0]    sel1;
  logic [2:0]    sel2;
  logic          found_nxt;
  logic [CW-1:0] e1_nxt [3];
  logic [CW-1:0] e2_nxt [3];

  always_comb begin
    logic kept;
    cnt  = '0;
    sel1 = '0;
    sel2 = '0;
    for (int f = 0; f < NF; f++) begin
      kept = okf_r[f] && !(|(eqf_r[f] & okf_r));
      if (kept) begin
        if (cnt == 3'd0) begin
          sel1 = 3'(f);
        end else if (cnt == 3'd1) begin
          sel2 = 3'(f);
        end
        cnt = cnt + 3'd1;
      end
    end
    found_nxt = (cnt == 3'd2);
    for (int k = 0; k < 3; k++) begin
      e1_nxt[k] = found_nxt ? lbc_pkg::sat32(hf_r[sel1][k]) : '0;
      e2_nxt[k] = found_nxt ? lbc_pkg::sat32(hf_r[sel2][k]) : '0;
    end
  end

  logic          found_r;
  logic [CW-1:0] e1_r [3];
  logic [CW-1:0] e2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      found_r <= found_nxt;
      e1_r    <= e1_nxt;
      e2_r    <= e2_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_found  = found_r;
  assign out_end1_x = e1_r[0];
  assign out_end1_y = e1_r[1];
  assign out_end1_z = e1_r[2];
  assign out_end2_x = e2_r[0];
  assign out_end2_y = e2_r[1];
  assign out_end2_z = e2_r[2];

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_end1_x == '0 && out_end1_y == '0
      && out_end1_z == '0 && out_end2_x == '0 && out_end2_y == '0 && out_end2_z == '0))
    else $error("miss result carries nonzero endpoints");

  a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (vf_r && !in_stall) |=> out_valid)
    else $error("request lost at output stage");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> ($stable(vf_r) && $stable(ve_r) && $stable(va_r)))
    else $error("pipeline moved during stall");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> va_r)
    else $error("accepted request not captured");
`endif

endmodule

### test/testbench.sv
// testbench for line_box_clip: random and directed lines clipped against
// configured boxes, checked against a built-in predictor; depends on lbc_pkg
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = lbc_pkg::FRAC_BITS_DEF;
  localparam longint TOL = ((longint'(1) << FB) + 500) / 1000;
  localparam longint QLIM = longint'(1) << 40;

  typedef struct packed {
    logic signed [31:0] px, py, pz, dx, dy, dz;
  } line_t;

  typedef struct packed {
    logic found;
    logic signed [31:0] ax, ay, az, bx, by, bz;
  } clip_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  line_t in_req = '0;
  logic out_valid;
  logic out_stall = 0;
  clip_t out_res;
  logic cfg_we = 0;
  lbc_pkg::cfg_reg_t cfg_index = lbc_pkg::REG_X_EXT;
  logic [lbc_pkg::EXT_W-1:0] cfg_data = '0;

  line_t pending[$];
  clip_t expected_clips[$];
  longint box_ext[3];
  int errors = 0;
  bit send_hold = 1;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  line_box_clip u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_point_x(in_req.px), .in_point_y(in_req.py), .in_point_z(in_req.pz),
    .in_dir_x(in_req.dx), .in_dir_y(in_req.dy), .in_dir_z(in_req.dz),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_found(out_res.found),
    .out_end1_x(out_res.ax), .out_end1_y(out_res.ay), .out_end1_z(out_res.az),
    .out_end2_x(out_res.bx), .out_end2_y(out_res.by), .out_end2_z(out_res.bz),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint offset_along(longint p, longint d, longint n, longint den);
    longint unsigned num, dm, q;
    bit neg;
    num = longint'(d < 0 ? -d : d) * longint'(n < 0 ? -n : n);
    dm = den < 0 ? -den : den;
    q = (2 * num + dm) / (2 * dm);
    neg = ((d < 0) != (n < 0)) != (den < 0);
    if (q > QLIM) q = QLIM;
    return neg ? p - longint'(q) : p + longint'(q);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic clip_t clip_line(line_t l);
    longint p[3], d[3], hits[6][3], h[3];
    longint c;
    int cnt, ax;
    bit ok, dup;
    clip_t r;
    p = '{l.px, l.py, l.pz};
    d = '{l.dx, l.dy, l.dz};
    cnt = 0;
    for (int f = 0; f < 6; f++) begin
      ax = 2 - (f % 3);
      c = (f < 3) ? 0 : box_ext[ax];
      if (d[ax] == 0) continue;
      ok = 1;
      for (int k = 0; k < 3; k++) begin
        h[k] = (k == ax) ? c : offset_along(p[k], d[k], c - p[ax], d[ax]);
        if (h[k] < -TOL || h[k] > box_ext[k] + TOL) ok = 0;
      end
      if (!ok) continue;
      dup = 0;
      for (int j = 0; j < cnt; j++)
        if (hits[j][0] == h[0] && hits[j][1] == h[1] && hits[j][2] == h[2]) dup = 1;
      if (!dup) begin
        hits[cnt] = h;
        cnt++;
      end
    end
    r = '0;
    if (cnt == 2) begin
      r.found = 1;
      r.ax = clamp32(hits[0][0]); r.ay = clamp32(hits[0][1]); r.az = clamp32(hits[0][2]);
      r.bx = clamp32(hits[1][0]); r.by = clamp32(hits[1][1]); r.bz = clamp32(hits[1][2]);
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      expected_clips = {expected_clips, clip_line(in_req)};
      void'(pending.pop_front());
    end
    if (in_valid && in_stall) begin
    end else if (!send_hold && pending.size() > 0 && (gap_left == 0)) begin
      in_valid <= 1;
      in_req <= pending[0];
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else burst_left--;
    end else begin
      in_valid <= 0;
      if (gap_left > 0) gap_left--;
      if (burst_left == 0 && gap_left == 0 && $urandom_range(0, 1)) burst_left = 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    clip_t e;
    if (out_valid && !out_stall) begin
      if (expected_clips.size() == 0) begin
        $error("result with nothing pending");
        errors++;
      end else begin
        e = expected_clips.pop_front();
        if (out_res.found !== e.found) begin
          $error("found exp %0d got %0d", e.found, out_res.found); errors++; end
        if (out_res.ax !== e.ax) begin
          $error("end1_x exp %0d got %0d", e.ax, out_res.ax); errors++; end
        if (out_res.ay !== e.ay) begin
          $error("end1_y exp %0d got %0d", e.ay, out_res.ay); errors++; end
        if (out_res.az !== e.az) begin
          $error("end1_z exp %0d got %0d", e.az, out_res.az); errors++; end
        if (out_res.bx !== e.bx) begin
          $error("end2_x exp %0d got %0d", e.bx, out_res.bx); errors++; end
        if (out_res.by !== e.by) begin
          $error("end2_y exp %0d got %0d", e.by, out_res.by); errors++; end
        if (out_res.bz !== e.bz) begin
          $error("end2_z exp %0d got %0d", e.bz, out_res.bz); errors++; end
      end
    end
    stall_phase <= stall_phase + 1;
    case ((stall_phase / 64) % 4)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ((stall_phase % 7) < 3);
      default: out_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  function automatic logic [31:0] rnd_coord(longint ext);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'(longint'($urandom_range(0, 3)) * ext / 2);
      2: return 32'($urandom_range(0, 32'h7fff_ffff) % (ext + 1));
      3: return 32'(-longint'($urandom_range(0, 200000)));
      default: return 32'(ext + $urandom_range(0, 200000) - 100000);
    endcase
  endfunction

  function automatic logic [31:0] rnd_dir();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return $urandom;
      2: return 32'(int'($urandom_range(0, 8)) - 4) <<< 16;
      default: return 32'(int'($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  task automatic write_box(longint x, longint y, longint z);
    longint v[3];
    v = '{x, y, z};
    for (int i = 0; i < 3; i++) begin
      @(posedge clk);
      cfg_we <= 1;
      cfg_index <= lbc_pkg::cfg_reg_t'(i);
      cfg_data <= v[i][lbc_pkg::EXT_W-1:0];
      box_ext[i] = v[i] & 64'h7fff_ffff;
    end
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    wait (pending.size() == 0 && !in_valid);
    send_hold = 1;
    wait (expected_clips.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic add_line(logic [31:0] px, py, pz, dx, dy, dz);
    line_t l;
    l = '{px, py, pz, dx, dy, dz};
    pending = {pending, l};
  endtask

  initial begin
    longint ex, ey, ez;
    box_ext = '{0, 0, 0};
    repeat (4) @(posedge clk);
    rst_n <= 1;
    write_box(10 << 16, 20 << 16, 30 << 16);
    // axis lines, corners, diagonals, zero direction, extremes
    add_line(5 << 16, 5 << 16, 5 << 16, 0, 0, 1 << 16);
    add_line(5 << 16, 5 << 16, 5 << 16, 1 << 16, 0, 0);
    add_line(5 << 16, 5 << 16, 5 << 16, 0, 1 << 16, 0);
    add_line(0, 0, 0, 1 << 16, 2 << 16, 3 << 16);
    add_line(0, 0, 0, 1 << 16, 1 << 16, 1 << 16);
    add_line(5 << 16, 5 << 16, 5 << 16, 0, 0, 0);
    add_line(0, 0, 0, 0, 0, -32'sd2147483648);
    add_line(32'h7fff_ffff, 32'h8000_0000, 0, 1, 32'h7fff_ffff, 32'h8000_0000);
    add_line(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 3, -5);
    add_line(10 << 16, 20 << 16, 30 << 16, -1, -2, -3);
    add_line(-66, 5 << 16, 5 << 16, 0, 0, 1);
    add_line(-67, 5 << 16, 5 << 16, 0, 0, 1);
    add_line(3, 7, 11, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_hold = 0;
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin ex = 0; ey = 0; ez = 0; end
        1: begin ex = 32'hffff_ffff; ey = 32'h7fff_ffff; ez = 32'h7fff_ffff; end
        2: begin ex = 1; ey = 1 << 16; ez = 32'h7fff_ffff; end
        default: begin
          ex = $urandom_range(1, 32'h7fff_ffff) >> $urandom_range(0, 24);
          ey = $urandom_range(1, 32'h7fff_ffff) >> $urandom_range(0, 24);
          ez = $urandom_range(1, 32'h7fff_ffff) >> $urandom_range(0, 24);
        end
      endcase
      write_box(ex, ey, ez);
      for (int i = 0; i < 100; i++)
        add_line(rnd_coord(box_ext[0]), rnd_coord(box_ext[1]), rnd_coord(box_ext[2]),
                 rnd_dir(), rnd_dir(), rnd_dir());
      send_hold = 0;
      drain();
    end
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
